### src/dme_pkg.sv
`default_nettype none

package dme_pkg;

    localparam int unsigned IN_DATA_W   = 64;
    localparam int unsigned IN_USER_W   = 2;
    localparam int unsigned OUT_DATA_W  = 160;
    localparam int unsigned OUT_USER_W  = 1;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam int unsigned NUM_W = 52;
    localparam int unsigned DEN_W = 32;
    localparam int unsigned REM_W = 33;
    localparam int unsigned CNT_W = 6;

    localparam logic [CNT_W-1:0] DIV_STEPS  = 6'd32;
    localparam logic [CNT_W-1:0] ROOT_STEPS = 6'd26;

    localparam logic [19:0] US_PER_S         = 20'd1000000;
    localparam logic [19:0] MIN_INTERVAL_RST = 20'd10000;

    localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;

    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_INTERVAL = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_POS_X  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_POS_Y  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_VEL_X  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_VEL_Y  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_ACCEL  = 3'd5;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_TOUCH = 2'd1,
        OP_MOVE  = 2'd2
    } op_t;

    typedef enum logic {
        MODE_DIV,
        MODE_ROOT
    } iter_mode_t;

    typedef struct packed {
        logic       start;
        iter_mode_t mode;
    } iter_req_t;

    typedef struct packed {
        logic done;
        logic ovf;
    } iter_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_VX_GO,
        ST_VX_WAIT,
        ST_VY_GO,
        ST_VY_WAIT,
        ST_SQX,
        ST_SQY,
        ST_ROOT_WAIT,
        ST_SPD_GO,
        ST_SPD_WAIT,
        ST_ACC_GO,
        ST_ACC_WAIT,
        ST_FINISH
    } state_t;

    function automatic logic [31:0] sat34(input logic [33:0] v);
        logic [31:0] r;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
            r = v[31:0];
        end else if (v[33]) begin
            r = S32_MIN;
        end else begin
            r = S32_MAX;
        end
        return r;
    endfunction

    // Turns a quotient magnitude and a sign into a saturated signed rate.
    function automatic logic [31:0] rate_from_quot(input logic [31:0] q, input logic ovf,
                                                   input logic neg);
        logic [31:0] r;
        if (ovf || q[31]) begin
            r = neg ? S32_MIN : S32_MAX;
        end else begin
            r = neg ? (32'd0 - q) : q;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### src/dme_iter_unit.sv
`default_nettype none

module dme_iter_unit (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire dme_pkg::iter_req_t       req,
    input  wire logic [dme_pkg::NUM_W-1:0] num,
    input  wire logic [dme_pkg::DEN_W-1:0] den,
    output dme_pkg::iter_rsp_t            rsp,
    output logic [31:0]                   quot
);
    import dme_pkg::*;

    iter_mode_t       mode_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             ovf_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [REM_W-1:0] rem_reg;
    logic [31:0]      acc_reg;
    logic [NUM_W-1:0] num_reg;

    logic [REM_W-1:0] sub_a;
    logic [REM_W-1:0] sub_b;
    logic [REM_W:0]   diff;
    logic             ge;
    logic             div_ovf;

    // One subtractor serves both the division and the square root steps.
    always_comb
    begin
        if (mode_reg == MODE_ROOT) begin
            sub_a = {rem_reg[30:0], num_reg[NUM_W-1 -: 2]};
            sub_b = {acc_reg[30:0], 2'b01};
        end else begin
            sub_a = {rem_reg[31:0], num_reg[NUM_W-1]};
            sub_b = {1'b0, den};
        end
        diff    = {1'b0, sub_a} - {1'b0, sub_b};
        ge      = ~diff[REM_W];
        div_ovf = ({12'd0, num[NUM_W-1:32]} >= den);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= MODE_DIV;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            acc_reg  <= '0;
            num_reg  <= '0;
        end else begin
            if (req.start) begin
                mode_reg <= req.mode;
                if (req.mode == MODE_ROOT) begin
                    ovf_reg  <= 1'b0;
                    acc_reg  <= '0;
                    done_reg <= 1'b0;
                    rem_reg  <= '0;
                    num_reg  <= num;
                    cnt_reg  <= ROOT_STEPS;
                    busy_reg <= 1'b1;
                end else if (div_ovf) begin
                    ovf_reg  <= 1'b1;
                    acc_reg  <= '1;
                    done_reg <= 1'b1;
                end else begin
                    ovf_reg  <= 1'b0;
                    acc_reg  <= '0;
                    done_reg <= 1'b0;
                    rem_reg  <= {13'd0, num[NUM_W-1:32]};
                    num_reg  <= {num[31:0], 20'd0};
                    cnt_reg  <= DIV_STEPS;
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                rem_reg <= ge ? diff[REM_W-1:0] : sub_a;
                acc_reg <= {acc_reg[30:0], ge};
                if (mode_reg == MODE_ROOT) begin
                    num_reg <= {num_reg[NUM_W-3:0], 2'b00};
                end else begin
                    num_reg <= {num_reg[NUM_W-2:0], 1'b0};
                end
                cnt_reg  <= cnt_reg - 6'd1;
                done_reg <= (cnt_reg == 6'd1);
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                end
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.ovf  = ovf_reg;
    assign quot     = acc_reg;

endmodule

`default_nettype wire

### src/drag_motion_estimator.sv
// Drag motion estimator. Pointer events enter as beats on the slave stream: tuser carries the
// operation (start, touch down, move) and tdata the pointer point and the microsecond stamp.
// Every accepted beat gives exactly one result beat on the master stream with the position,
// velocity and filtered acceleration after the event, and a tuser flag that is set when the
// event recomputed the rates. The user must write the registers through the plain write port
// only while the block is idle; the block itself does not enforce this.
// A start, touch, unused or short-interval move beat passes through the decode and finish
// states into the output register, and the block is ready for the next beat while that result
// is presented. A move that recomputes the rates runs four 32-step divisions and one 26-step
// square root on a single shared shift-subtract unit before its result is registered; a
// division whose quotient is known to saturate skips its steps. The block takes one event at
// a time and is not ready while it works.
// The result is held in an output register, so the next event is accepted while a finished
// result waits for the receiver; when the receiver stalls, a finished second result waits in
// the block until the register frees. Reset clears all motion state to zero and loads the
// register defaults (minimum interval 10000 us).
`default_nettype none

module drag_motion_estimator (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // ptr_x [15:0], ptr_y [31:16], stamp_us [63:32]
    input  wire logic [dme_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // op [1:0]
    input  wire logic [dme_pkg::IN_USER_W-1:0]    s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // pos_x [31:0], pos_y [63:32], vel_x [95:64], vel_y [127:96], accel_out [159:128]
    output logic [dme_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    // rates_fresh [0]
    output logic [dme_pkg::OUT_USER_W-1:0]        m_axis_tuser,
    input  wire logic                             cfg_we,
    input  wire logic [dme_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [dme_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import dme_pkg::*;

    state_t state_reg, state_next;

    logic [19:0] min_interval_reg;
    logic [31:0] start_pos_x_reg, start_pos_y_reg;
    logic [31:0] start_vel_x_reg, start_vel_y_reg;
    logic [31:0] start_accel_reg;

    logic [31:0] pos_x_reg, pos_y_reg;
    logic [15:0] last_ptr_x_reg, last_ptr_y_reg;
    logic [31:0] last_stamp_reg;
    logic [31:0] vel_x_reg, vel_y_reg;
    logic [31:0] speed_reg;
    logic [31:0] accel_reg;

    op_t         op_reg;
    logic [15:0] px_reg, py_reg;
    logic [31:0] stamp_reg;
    logic [31:0] dt_reg;
    logic [15:0] dx_mag_reg, dy_mag_reg;
    logic        dx_neg_reg, dy_neg_reg;
    logic        fresh_reg;
    logic [31:0] sq_reg;
    logic [31:0] dspd_mag_reg;
    logic        dspd_neg_reg;

    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_fresh_reg;
    logic                  out_valid_reg;

    logic             accept;
    logic             out_free;
    logic [31:0]      dt;
    logic             dt_gt;
    logic [33:0]      sum_x, sum_y;
    logic [31:0]      new_x, new_y;
    logic [32:0]      dx_full, dy_full;
    logic [32:0]      dx_abs, dy_abs;
    logic [31:0]      mul_a;
    logic [19:0]      mul_b;
    logic [51:0]      mul_out;
    logic [32:0]      sq_sum;
    logic [NUM_W-1:0] iter_num;
    iter_req_t        iter_req;
    iter_rsp_t        iter_rsp;
    logic [31:0]      iter_quot;
    logic [31:0]      new_speed;
    logic [31:0]      dspd;
    logic [31:0]      half_accel;
    logic [31:0]      term_mag;
    logic [33:0]      term;
    logic [33:0]      accel_sum;

    function automatic logic [15:0] clamp_ptr(input logic [31:0] p);
        logic [15:0] r;
        if (p[31]) begin
            r = 16'd0;
        end else if (p[30:16] != 15'd0) begin
            r = 16'hFFFF;
        end else begin
            r = p[15:0];
        end
        return r;
    endfunction

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        dt      = stamp_reg - last_stamp_reg;
        dt_gt   = (dt > {12'd0, min_interval_reg});
        sum_x   = {{2{pos_x_reg[31]}}, pos_x_reg} + {18'd0, px_reg} - {18'd0, last_ptr_x_reg};
        sum_y   = {{2{pos_y_reg[31]}}, pos_y_reg} + {18'd0, py_reg} - {18'd0, last_ptr_y_reg};
        new_x   = sat34(sum_x);
        new_y   = sat34(sum_y);
        dx_full = {new_x[31], new_x} - {pos_x_reg[31], pos_x_reg};
        dy_full = {new_y[31], new_y} - {pos_y_reg[31], pos_y_reg};
        dx_abs  = dx_full[32] ? (33'd0 - dx_full) : dx_full;
        dy_abs  = dy_full[32] ? (33'd0 - dy_full) : dy_full;

        new_speed  = (iter_rsp.ovf || iter_quot[31]) ? S32_MAX : iter_quot;
        dspd       = new_speed - speed_reg;
        half_accel = {accel_reg[31], accel_reg[31:1]};
        term_mag   = iter_rsp.ovf ? 32'hFFFF_FFFF : iter_quot;
        term       = dspd_neg_reg ? (34'd0 - {2'b00, term_mag}) : {2'b00, term_mag};
        accel_sum  = {{2{half_accel[31]}}, half_accel} + term;

        mul_out = 52'(mul_a) * 52'(mul_b);
        sq_sum  = {1'b0, sq_reg} + {1'b0, mul_out[31:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        s_axis_tready  = 1'b0;
        iter_req.start = 1'b0;
        iter_req.mode  = MODE_DIV;
        mul_a          = 32'd0;
        mul_b          = 20'd0;
        iter_num       = mul_out;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (op_reg == OP_MOVE && dt_gt) begin
                    state_next = ST_VX_GO;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_VX_GO:
            begin
                mul_a          = {16'd0, dx_mag_reg};
                mul_b          = US_PER_S;
                iter_req.start = 1'b1;
                state_next     = ST_VX_WAIT;
            end
            ST_VX_WAIT:
            begin
                if (iter_rsp.done) begin
                    state_next = ST_VY_GO;
                end
            end
            ST_VY_GO:
            begin
                mul_a          = {16'd0, dy_mag_reg};
                mul_b          = US_PER_S;
                iter_req.start = 1'b1;
                state_next     = ST_VY_WAIT;
            end
            ST_VY_WAIT:
            begin
                if (iter_rsp.done) begin
                    state_next = ST_SQX;
                end
            end
            ST_SQX:
            begin
                mul_a      = {16'd0, dx_mag_reg};
                mul_b      = {4'd0, dx_mag_reg};
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                mul_a          = {16'd0, dy_mag_reg};
                mul_b          = {4'd0, dy_mag_reg};
                iter_num       = {3'd0, sq_sum, 16'd0};
                iter_req.start = 1'b1;
                iter_req.mode  = MODE_ROOT;
                state_next     = ST_ROOT_WAIT;
            end
            ST_ROOT_WAIT:
            begin
                if (iter_rsp.done) begin
                    state_next = ST_SPD_GO;
                end
            end
            ST_SPD_GO:
            begin
                mul_a          = iter_quot;
                mul_b          = US_PER_S;
                iter_num       = {8'd0, mul_out[51:8]};
                iter_req.start = 1'b1;
                state_next     = ST_SPD_WAIT;
            end
            ST_SPD_WAIT:
            begin
                if (iter_rsp.done) begin
                    state_next = ST_ACC_GO;
                end
            end
            ST_ACC_GO:
            begin
                mul_a          = dspd_mag_reg;
                mul_b          = US_PER_S;
                iter_req.start = 1'b1;
                state_next     = ST_ACC_WAIT;
            end
            ST_ACC_WAIT:
            begin
                if (iter_rsp.done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            min_interval_reg <= MIN_INTERVAL_RST;
            start_pos_x_reg  <= '0;
            start_pos_y_reg  <= '0;
            start_vel_x_reg  <= '0;
            start_vel_y_reg  <= '0;
            start_accel_reg  <= '0;
            pos_x_reg        <= '0;
            pos_y_reg        <= '0;
            last_ptr_x_reg   <= '0;
            last_ptr_y_reg   <= '0;
            last_stamp_reg   <= '0;
            vel_x_reg        <= '0;
            vel_y_reg        <= '0;
            speed_reg        <= '0;
            accel_reg        <= '0;
            fresh_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_MIN_INTERVAL: min_interval_reg <= cfg_data[19:0];
                    CFG_START_POS_X:  start_pos_x_reg  <= cfg_data;
                    CFG_START_POS_Y:  start_pos_y_reg  <= cfg_data;
                    CFG_START_VEL_X:  start_vel_x_reg  <= cfg_data;
                    CFG_START_VEL_Y:  start_vel_y_reg  <= cfg_data;
                    CFG_START_ACCEL:  start_accel_reg  <= cfg_data;
                    default:          ;
                endcase
            end

            if (state_reg == ST_FINISH && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_DECODE:
                begin
                    fresh_reg <= (op_reg == OP_MOVE) && dt_gt;
                    case (op_reg)
                        OP_START:
                        begin
                            pos_x_reg      <= start_pos_x_reg;
                            pos_y_reg      <= start_pos_y_reg;
                            vel_x_reg      <= start_vel_x_reg;
                            vel_y_reg      <= start_vel_y_reg;
                            accel_reg      <= start_accel_reg;
                            last_ptr_x_reg <= clamp_ptr(start_pos_x_reg);
                            last_ptr_y_reg <= clamp_ptr(start_pos_y_reg);
                            last_stamp_reg <= stamp_reg;
                            speed_reg      <= '0;
                        end
                        OP_TOUCH:
                        begin
                            last_ptr_x_reg <= px_reg;
                            last_ptr_y_reg <= py_reg;
                            last_stamp_reg <= stamp_reg;
                        end
                        OP_MOVE:
                        begin
                            pos_x_reg      <= new_x;
                            pos_y_reg      <= new_y;
                            last_ptr_x_reg <= px_reg;
                            last_ptr_y_reg <= py_reg;
                            if (dt_gt) begin
                                last_stamp_reg <= stamp_reg;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                ST_VX_WAIT:
                begin
                    if (iter_rsp.done) begin
                        vel_x_reg <= rate_from_quot(iter_quot, iter_rsp.ovf, dx_neg_reg);
                    end
                end
                ST_VY_WAIT:
                begin
                    if (iter_rsp.done) begin
                        vel_y_reg <= rate_from_quot(iter_quot, iter_rsp.ovf, dy_neg_reg);
                    end
                end
                ST_SPD_WAIT:
                begin
                    if (iter_rsp.done) begin
                        speed_reg <= new_speed;
                    end
                end
                ST_ACC_WAIT:
                begin
                    if (iter_rsp.done) begin
                        accel_reg <= sat34(accel_sum);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Item and working registers; no reset needed.
    always_ff @(posedge clk)
    begin
        if (accept) begin
            op_reg    <= op_t'(s_axis_tuser);
            px_reg    <= s_axis_tdata[15:0];
            py_reg    <= s_axis_tdata[31:16];
            stamp_reg <= s_axis_tdata[63:32];
        end
        if (state_reg == ST_DECODE) begin
            dt_reg     <= dt;
            dx_mag_reg <= dx_abs[15:0];
            dy_mag_reg <= dy_abs[15:0];
            dx_neg_reg <= dx_full[32];
            dy_neg_reg <= dy_full[32];
        end
        if (state_reg == ST_SQX) begin
            sq_reg <= mul_out[31:0];
        end
        if (state_reg == ST_SPD_WAIT && iter_rsp.done) begin
            dspd_neg_reg <= dspd[31];
            dspd_mag_reg <= dspd[31] ? (32'd0 - dspd) : dspd;
        end
        if (state_reg == ST_FINISH && out_free) begin
            out_data_reg  <= {accel_reg, vel_y_reg, vel_x_reg, pos_y_reg, pos_x_reg};
            out_fresh_reg <= fresh_reg;
        end
    end

    dme_iter_unit u_iter (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (iter_req),
        .num   (iter_num),
        .den   (dt_reg),
        .rsp   (iter_rsp),
        .quot  (iter_quot)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_fresh_reg;

endmodule

`default_nettype wire

### tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dme_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam longint RATE_SCALE = 64'sd1000000;
    localparam longint S32_HI = 64'sh7FFF_FFFF;
    localparam longint S32_LO = -64'sh8000_0000;

    localparam int NUM_PHASES = 6;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int HOLD_CYCLES = 600;
    localparam int END_SETTLE = 250;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] accel;
        logic        fresh;
    } motion_result_t;

    typedef struct packed {
        logic [19:0] min_interval;
        logic [31:0] start_pos_x;
        logic [31:0] start_pos_y;
        logic [31:0] start_vel_x;
        logic [31:0] start_vel_y;
        logic [31:0] start_accel;
    } reg_set_t;

    typedef struct packed {
        logic           is_settings;
        logic           typed;
        logic [1:0]     op;
        logic [15:0]    px;
        logic [15:0]    py;
        logic [31:0]    stamp;
        motion_result_t want;
        reg_set_t       regs;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic [IN_USER_W-1:0]   s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic [OUT_USER_W-1:0]  m_axis_tuser;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Tracker of the dragged object, kept alongside the block.
    reg_set_t           active_regs;
    logic signed [31:0] trk_pos_x = '0;
    logic signed [31:0] trk_pos_y = '0;
    logic [15:0]        trk_last_x = '0;
    logic [15:0]        trk_last_y = '0;
    logic [31:0]        trk_last_stamp = '0;
    logic signed [31:0] trk_vel_x = '0;
    logic signed [31:0] trk_vel_y = '0;
    logic signed [31:0] trk_speed = '0;
    logic signed [31:0] trk_accel = '0;

    motion_result_t expected_motion[$];
    stim_row_t      directed_rows[$];

    int          fail_count = 0;
    int          items_sent = 0;
    int          cycle_count = 0;
    int unsigned send_idle_pct = 19;
    int unsigned recv_idle_pct = 60;
    logic        hold_request = 1'b0;
    logic        hold_taken = 1'b0;
    int          hold_left = 0;
    logic [31:0] clock_us = '0;

    drag_motion_estimator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] clip_s32(input longint v);
        if (v > S32_HI)
        begin
            return 32'h7FFF_FFFF;
        end
        if (v < S32_LO)
        begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [15:0] clamp_ptr16(input logic signed [31:0] p);
        if (p < 0)
        begin
            return 16'd0;
        end
        if (p > 32'sd65535)
        begin
            return 16'hFFFF;
        end
        return p[15:0];
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = 25; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if (c * c <= n)
            begin
                r = c;
            end
        end
        return r;
    endfunction

    function automatic motion_result_t predict_motion(input logic [1:0] op,
                                                      input logic [15:0] px,
                                                      input logic [15:0] py,
                                                      input logic [31:0] stamp);
        motion_result_t r;
        longint         old_x;
        longint         old_y;
        longint         dx;
        longint         dy;
        longint         span;
        longint         acc;
        logic [63:0]    sq;
        logic [63:0]    len;
        logic [63:0]    spd;
        logic [31:0]    dt;
        logic           fresh;
        fresh = 1'b0;
        if (op == OP_START)
        begin
            trk_pos_x = active_regs.start_pos_x;
            trk_pos_y = active_regs.start_pos_y;
            trk_vel_x = active_regs.start_vel_x;
            trk_vel_y = active_regs.start_vel_y;
            trk_accel = active_regs.start_accel;
            trk_last_x = clamp_ptr16(trk_pos_x);
            trk_last_y = clamp_ptr16(trk_pos_y);
            trk_last_stamp = stamp;
            trk_speed = '0;
        end
        else if (op == OP_TOUCH)
        begin
            trk_last_x = px;
            trk_last_y = py;
            trk_last_stamp = stamp;
        end
        else if (op == OP_MOVE)
        begin
            old_x = longint'(trk_pos_x);
            old_y = longint'(trk_pos_y);
            trk_pos_x = clip_s32(old_x + longint'({48'd0, px}) - longint'({48'd0, trk_last_x}));
            trk_pos_y = clip_s32(old_y + longint'({48'd0, py}) - longint'({48'd0, trk_last_y}));
            trk_last_x = px;
            trk_last_y = py;
            dt = stamp - trk_last_stamp;
            if (dt > {12'd0, active_regs.min_interval})
            begin
                dx = longint'(trk_pos_x) - old_x;
                dy = longint'(trk_pos_y) - old_y;
                span = longint'({32'd0, dt});
                trk_last_stamp = stamp;
                trk_vel_x = clip_s32(dx * RATE_SCALE / span);
                trk_vel_y = clip_s32(dy * RATE_SCALE / span);
                sq = dx * dx + dy * dy;
                len = root_floor(sq << 16);
                spd = (len * 64'd1000000) / ({32'd0, dt} << 8);
                if (spd > 64'h7FFF_FFFF)
                begin
                    spd = 64'h7FFF_FFFF;
                end
                acc = (longint'(trk_accel) >>> 1)
                    + (longint'(spd) - longint'(trk_speed)) * RATE_SCALE / span;
                trk_speed = spd[31:0];
                trk_accel = clip_s32(acc);
                fresh = 1'b1;
            end
        end
        r.pos_x = trk_pos_x;
        r.pos_y = trk_pos_y;
        r.vel_x = trk_vel_x;
        r.vel_y = trk_vel_y;
        r.accel = trk_accel;
        r.fresh = fresh;
        return r;
    endfunction

    function automatic stim_row_t ev(input logic [1:0] op, input logic [15:0] px,
                                     input logic [15:0] py, input logic [31:0] stamp);
        stim_row_t r;
        r = '0;
        r.op = op;
        r.px = px;
        r.py = py;
        r.stamp = stamp;
        return r;
    endfunction

    function automatic stim_row_t ev_typed(input logic [1:0] op, input logic [15:0] px,
                                           input logic [15:0] py, input logic [31:0] stamp,
                                           input motion_result_t want);
        stim_row_t r;
        r = ev(op, px, py, stamp);
        r.typed = 1'b1;
        r.want = want;
        return r;
    endfunction

    function automatic stim_row_t settings_row(input reg_set_t s);
        stim_row_t r;
        r = '0;
        r.is_settings = 1'b1;
        r.regs = s;
        return r;
    endfunction

    function automatic logic [31:0] random_s32();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 15)
        begin
            return 32'h7FFF_FFFF;
        end
        if (r < 30)
        begin
            return 32'h8000_0000;
        end
        if (r < 65)
        begin
            return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
        end
        return $urandom;
    endfunction

    function automatic reg_set_t random_settings();
        reg_set_t s;
        case ($urandom_range(5))
            0: s.min_interval = 20'd0;
            1: s.min_interval = 20'd1;
            2: s.min_interval = 20'd1000000;
            3: s.min_interval = MIN_INTERVAL_RST;
            4: s.min_interval = 20'($urandom_range(1, 5000));
            default: s.min_interval = 20'($urandom_range(1, 1000000));
        endcase
        s.start_pos_x = random_s32();
        s.start_pos_y = random_s32();
        s.start_vel_x = random_s32();
        s.start_vel_y = random_s32();
        s.start_accel = random_s32();
        return s;
    endfunction

    function automatic logic [31:0] pick_interval();
        logic [31:0] m;
        int unsigned r;
        m = {12'd0, active_regs.min_interval};
        r = $urandom_range(99);
        if (r < 45)
        begin
            return m + 1 + $urandom_range(0, 20000);
        end
        if (r < 65)
        begin
            return $urandom_range(0, m);
        end
        if (r < 75)
        begin
            return m;
        end
        if (r < 82)
        begin
            return m + 1;
        end
        if (r < 94)
        begin
            return $urandom_range(1, 20);
        end
        return $urandom;
    endfunction

    function automatic logic [15:0] walk_coord(input logic [15:0] c);
        int v;
        if ($urandom_range(99) < 20)
        begin
            return 16'($urandom);
        end
        v = int'(c) + int'($urandom_range(0, 6000)) - 3000;
        if (v < 0)
        begin
            v = 0;
        end
        if (v > 65535)
        begin
            v = 65535;
        end
        return 16'(v);
    endfunction

    task automatic drain_stream();
        s_axis_tvalid <= 1'b0;
        while (expected_motion.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic apply_settings(input reg_set_t s);
        logic [CFG_INDEX_W-1:0] reg_ids[6];
        logic [31:0]            vals[6];
        reg_ids = '{CFG_MIN_INTERVAL, CFG_START_POS_X, CFG_START_POS_Y,
                    CFG_START_VEL_X, CFG_START_VEL_Y, CFG_START_ACCEL};
        vals = '{{12'd0, s.min_interval}, s.start_pos_x, s.start_pos_y,
                 s.start_vel_x, s.start_vel_y, s.start_accel};
        drain_stream();
        for (int i = 0; i < 6; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= reg_ids[i];
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        active_regs = s;
    endtask

    task automatic push_event(input stim_row_t row);
        motion_result_t want;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {row.stamp, row.py, row.px};
        s_axis_tuser <= row.op;
        do
        begin
            @(posedge clk);
        end
        while (s_axis_tready !== 1'b1);
        want = predict_motion(row.op, row.px, row.py, row.stamp);
        expected_motion.push_back(row.typed ? row.want : want);
        items_sent++;
    endtask

    task automatic drive_session();
        logic [15:0] cx;
        logic [15:0] cy;
        int          moves;
        if ($urandom_range(9) == 0)
        begin
            clock_us = 32'hFFFF_FFFF - $urandom_range(0, 2000000);
        end
        else
        begin
            clock_us = clock_us + $urandom_range(0, 100000);
        end
        push_event(ev(OP_START, 16'($urandom), 16'($urandom), clock_us));
        cx = trk_last_x;
        cy = trk_last_y;
        if ($urandom_range(1) == 1)
        begin
            clock_us = clock_us + $urandom_range(0, 2000);
            cx = 16'($urandom);
            cy = 16'($urandom);
            push_event(ev(OP_TOUCH, cx, cy, clock_us));
        end
        moves = $urandom_range(3, 10);
        repeat (moves)
        begin
            clock_us = clock_us + pick_interval();
            cx = walk_coord(cx);
            cy = walk_coord(cy);
            if ($urandom_range(11) == 0)
            begin
                push_event(ev(OP_TOUCH, cx, cy, clock_us));
            end
            else
            begin
                push_event(ev(OP_MOVE, cx, cy, clock_us));
            end
        end
    endtask

    always @(posedge clk)
    begin : result_side
        motion_result_t got;
        motion_result_t want;
        if (rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
        begin
            got.pos_x = m_axis_tdata[31:0];
            got.pos_y = m_axis_tdata[63:32];
            got.vel_x = m_axis_tdata[95:64];
            got.vel_y = m_axis_tdata[127:96];
            got.accel = m_axis_tdata[159:128];
            got.fresh = m_axis_tuser[0];
            if (expected_motion.size() == 0)
            begin
                $error("result beat with nothing expected: tdata %h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = expected_motion.pop_front();
                if (got.pos_x !== want.pos_x)
                begin
                    $error("pos_x: expected %h, got %h", want.pos_x, got.pos_x);
                    fail_count++;
                end
                if (got.pos_y !== want.pos_y)
                begin
                    $error("pos_y: expected %h, got %h", want.pos_y, got.pos_y);
                    fail_count++;
                end
                if (got.vel_x !== want.vel_x)
                begin
                    $error("vel_x: expected %h, got %h", want.vel_x, got.vel_x);
                    fail_count++;
                end
                if (got.vel_y !== want.vel_y)
                begin
                    $error("vel_y: expected %h, got %h", want.vel_y, got.vel_y);
                    fail_count++;
                end
                if (got.accel !== want.accel)
                begin
                    $error("accel_out: expected %h, got %h", want.accel, got.accel);
                    fail_count++;
                end
                if (got.fresh !== want.fresh)
                begin
                    $error("rates_fresh: expected %b, got %b", want.fresh, got.fresh);
                    fail_count++;
                end
            end
        end
        if (hold_request && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        int   ph;
        int   phase_start;
        logic paused;
        paused = 1'b0;
        active_regs = '0;
        active_regs.min_interval = MIN_INTERVAL_RST;

        // Register defaults first, then the extremes of every register.
        directed_rows.push_back(ev_typed(OP_TOUCH, 16'h0000, 16'h0000, 32'h0000_0000,
            '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0}));
        directed_rows.push_back(ev_typed(OP_UNUSED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
            '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0}));
        directed_rows.push_back(ev_typed(OP_MOVE, 16'hFFFF, 16'hFFFF, 32'd5000,
            '{32'h0000_FFFF, 32'h0000_FFFF, 32'h0, 32'h0, 32'h0, 1'b0}));
        directed_rows.push_back(ev(OP_MOVE, 16'h0000, 16'h0000, 32'd20000));
        directed_rows.push_back(ev(OP_MOVE, 16'h8000, 16'h1234, 32'd30000));
        directed_rows.push_back(ev(OP_MOVE, 16'h8001, 16'h1200, 32'd30001));
        directed_rows.push_back(ev(OP_TOUCH, 16'h1234, 16'hFFFF, 32'hFFFF_F000));
        directed_rows.push_back(ev(OP_MOVE, 16'h0000, 16'h0000, 32'h0001_0000));
        directed_rows.push_back(settings_row('{20'd0, 32'h7FFF_0000, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000}));
        directed_rows.push_back(ev_typed(OP_START, 16'hAAAA, 16'h5555, 32'h5555_5555,
            '{32'h7FFF_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
              1'b0}));
        directed_rows.push_back(ev_typed(OP_MOVE, 16'hFFFF, 16'h0000, 32'h5555_5556,
            '{32'h7FFF_0000, 32'h8000_0000, 32'h0, 32'h0, 32'hC000_0000, 1'b1}));
        directed_rows.push_back(ev(OP_TOUCH, 16'h0000, 16'hFFFF, 32'h5555_5557));
        directed_rows.push_back(ev(OP_MOVE, 16'hFFFF, 16'h0000, 32'h5555_5558));
        directed_rows.push_back(ev(OP_MOVE, 16'h0000, 16'hFFFF, 32'h5555_5559));
        directed_rows.push_back(ev(OP_MOVE, 16'h7FFF, 16'h8000, 32'h5555_5558));
        directed_rows.push_back(settings_row('{20'd1000000, 32'hFFFF_FFFB, 32'h0001_0000,
            32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF}));
        directed_rows.push_back(ev_typed(OP_START, 16'h0F0F, 16'hF0F0, 32'h0000_0000,
            '{32'hFFFF_FFFB, 32'h0001_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
              1'b0}));
        directed_rows.push_back(ev(OP_MOVE, 16'd100, 16'hFFFF, 32'd1000000));
        directed_rows.push_back(ev(OP_MOVE, 16'd200, 16'h0000, 32'd1000001));
        directed_rows.push_back(ev(OP_UNUSED, 16'h5A5A, 16'hA5A5, 32'hDEAD_BEEF));

        repeat (4)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_settings)
            begin
                apply_settings(directed_rows[i].regs);
            end
            else
            begin
                push_event(directed_rows[i]);
            end
        end

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            send_idle_pct = (ph < 2) ? 19 : (ph < 4) ? 60 : 0;
            recv_idle_pct = (ph < 2) ? 60 : (ph < 4) ? 19 : 0;
            apply_settings(random_settings());
            phase_start = items_sent;
            while (items_sent - phase_start < ITEMS_PER_PHASE)
            begin
                if (ph == 1 && items_sent - phase_start >= 30)
                begin
                    hold_request = 1'b1;
                end
                if (ph == 3 && !paused && items_sent - phase_start >= 30)
                begin
                    paused = 1'b1;
                    drain_stream();
                end
                if ($urandom_range(9) == 0)
                begin
                    push_event(ev(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                                  $urandom));
                end
                else
                begin
                    drive_session();
                end
            end
        end

        drain_stream();
        repeat (END_SETTLE)
        begin
            @(posedge clk);
        end
        if (fail_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
